### rtl/sorted_color_key_lookup_insert_macros.svh
// assertion macros for the checker file
// the enclosing module provides clock and reset
`ifndef SORTED_COLOR_KEY_LOOKUP_INSERT_MACROS_SVH
`define SORTED_COLOR_KEY_LOOKUP_INSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SCKL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define SCKL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sckl_pkg.sv
// ----------------------------------------------------------------------------
// sckl_pkg
// shared constants and types of the sorted color key lookup
// ----------------------------------------------------------------------------
package sckl_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int COLOR_W     = 8;
   localparam int PIX_W       = 8;
   localparam int KEY_W       = 3 * COLOR_W;

   // match flags are or-reduced in groups, then across groups
   localparam int GRP_SIZE  = 16;
   localparam int GRP_COUNT = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
   localparam int PAD_DEPTH = GRP_COUNT * GRP_SIZE;

   // contents of one table cell
   typedef struct packed {
      logic             vld;
      logic [KEY_W-1:0] key;
      logic [PIX_W-1:0] pix;
   } cell_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             insert;
      logic [KEY_W-1:0] key;
      logic [PIX_W-1:0] pix;
   } cmd_type;

   // registered compare result of one cell
   typedef struct packed {
      logic gt;   // cell empty or its key above the search key
      logic eq;   // cell valid and its key equal to the search key
   } flag_type;

endpackage

### rtl/sckl_ifs.sv
// ----------------------------------------------------------------------------
// sckl interfaces
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface sckl_req_if;
   logic                        valid;
   logic                        ready;
   logic [sckl_pkg::COLOR_W-1:0] red;
   logic [sckl_pkg::COLOR_W-1:0] green;
   logic [sckl_pkg::COLOR_W-1:0] blue;
   logic [sckl_pkg::PIX_W-1:0]   alloc_pixel;

   modport source (output valid, red, green, blue, alloc_pixel, input ready);
   modport sink   (input valid, red, green, blue, alloc_pixel, output ready);
endinterface

interface sckl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [sckl_pkg::PIX_W-1:0] pixel_index;
   logic                      hit;
   logic                      table_full;

   modport source (output valid, pixel_index, hit, table_full, input ready);
   modport sink   (input valid, pixel_index, hit, table_full, output ready);
endinterface

### rtl/sorted_color_key_lookup_insert.sv
// ----------------------------------------------------------------------------
// sorted_color_key_lookup_insert
// color key to pixel lookup over a sorted chain of cells with a one-entry cache
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_bus   in         red, green, blue, alloc_pixel
//  rsp_bus   out        pixel_index, hit, table_full
//
//  one item at a time: after the request transfer a cache hit goes straight to
//  the response state, a table lookup or insert first passes cell compare,
//  registered group or, registered final or and decide
//  an insert shifts all larger cells up by one in the same cycle
//  reset empties cache and table at once, no clearing pass
//  a held response does not block the next request, only the next result
// ----------------------------------------------------------------------------
module sorted_color_key_lookup_insert (
   input  logic      clock,
   input  logic      reset,
   sckl_req_if.sink   req_bus,
   sckl_rsp_if.source rsp_bus
);

   // controller states
   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request transfer
   localparam logic [2:0] ST_LOOK = 3'd1;  // cache check, cells compare
   localparam logic [2:0] ST_GRP  = 3'd2;  // group or of match flags
   localparam logic [2:0] ST_SUM  = 3'd3;  // or across groups
   localparam logic [2:0] ST_DEC  = 3'd4;  // hit, full or insert
   localparam logic [2:0] ST_RESP = 3'd5;  // hand result to output register

   logic [2:0] state_ff, state_in;

   // request held for the whole search
   logic [sckl_pkg::KEY_W-1:0] key_ff, key_in;
   logic [sckl_pkg::PIX_W-1:0] apix_ff, apix_in;

   // one-entry cache of the last table hit
   logic                       last_vld_ff, last_vld_in;
   logic [sckl_pkg::KEY_W-1:0] last_key_ff, last_key_in;
   logic [sckl_pkg::PIX_W-1:0] last_pix_ff, last_pix_in;

   // result waiting for the output register
   logic [sckl_pkg::PIX_W-1:0] res_pix_ff, res_pix_in;
   logic                       res_hit_ff, res_hit_in;
   logic                       res_full_ff, res_full_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [sckl_pkg::PIX_W-1:0] rsp_pix_ff, rsp_pix_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic                       rsp_full_ff, rsp_full_in;

   // chain of cells
   sckl_pkg::cmd_type  cmd;
   sckl_pkg::cell_type cells [sckl_pkg::TABLE_DEPTH];
   logic               eq_vec  [sckl_pkg::PAD_DEPTH];
   logic               gt_vec  [sckl_pkg::TABLE_DEPTH];
   logic [sckl_pkg::PIX_W-1:0] pix_vec [sckl_pkg::PAD_DEPTH];

   // match reduction
   logic                       grp_hit_ff [sckl_pkg::GRP_COUNT];
   logic [sckl_pkg::PIX_W-1:0] grp_pix_ff [sckl_pkg::GRP_COUNT];
   logic                       grp_hit_in [sckl_pkg::GRP_COUNT];
   logic [sckl_pkg::PIX_W-1:0] grp_pix_in [sckl_pkg::GRP_COUNT];
   logic                       sum_hit_ff, sum_hit_in;
   logic [sckl_pkg::PIX_W-1:0] sum_pix_ff, sum_pix_in;

   logic req_xfer;
   logic out_free;
   logic cache_hit;
   logic table_full;

   assign req_xfer   = req_bus.valid && req_bus.ready;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign cache_hit  = last_vld_ff && (last_key_ff == key_ff);
   // the table is full once the top cell holds an entry
   assign table_full = cells[sckl_pkg::TABLE_DEPTH-1].vld;

   // ---------------------------------------------------------------------
   // cell chain, cell 0 holds the smallest key
   // ---------------------------------------------------------------------
   assign cmd.key    = key_ff;
   assign cmd.pix    = apix_ff;
   assign cmd.insert = (state_ff == ST_DEC) && !sum_hit_ff && !table_full;

   for (genvar i = 0; i < sckl_pkg::TABLE_DEPTH; i++) begin : g_cell
      sckl_pkg::flag_type flag;
      sckl_pkg::cell_type prev_cell;
      logic               prev_gt;

      if (i == 0) begin : g_first
         // nothing below cell 0, so if it moves on an insert it loads the new entry
         assign prev_cell = '0;
         assign prev_gt   = 1'b0;
      end else begin : g_rest
         assign prev_cell = cells[i-1];
         assign prev_gt   = gt_vec[i-1];
      end

      sckl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_cell (prev_cell),
         .prev_gt   (prev_gt),
         .cell_out  (cells[i]),
         .flag      (flag)
      );

      assign gt_vec[i]  = flag.gt;
      assign eq_vec[i]  = flag.eq;
      assign pix_vec[i] = cells[i].pix;
   end

   // padding up to a whole number of groups never matches
   for (genvar p = sckl_pkg::TABLE_DEPTH; p < sckl_pkg::PAD_DEPTH; p++) begin : g_pad
      assign eq_vec[p]  = 1'b0;
      assign pix_vec[p] = '0;
   end

   // ---------------------------------------------------------------------
   // match reduction: keys are unique, so at most one cell matches
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < sckl_pkg::GRP_COUNT; g++) begin : g_grp
      always_comb begin
         grp_hit_in[g] = 1'b0;
         grp_pix_in[g] = '0;
         for (int j = 0; j < sckl_pkg::GRP_SIZE; j++) begin
            if (eq_vec[g*sckl_pkg::GRP_SIZE + j]) begin
               grp_hit_in[g] = 1'b1;
               grp_pix_in[g] = grp_pix_in[g] | pix_vec[g*sckl_pkg::GRP_SIZE + j];
            end
         end
      end

      always_ff @(posedge clock) begin
         grp_hit_ff[g] <= grp_hit_in[g];
         grp_pix_ff[g] <= grp_pix_in[g];
      end
   end

   always_comb begin
      sum_hit_in = 1'b0;
      sum_pix_in = '0;
      for (int g = 0; g < sckl_pkg::GRP_COUNT; g++) begin
         sum_hit_in = sum_hit_in | grp_hit_ff[g];
         sum_pix_in = sum_pix_in | grp_pix_ff[g];
      end
   end

   // ---------------------------------------------------------------------
   // controller
   // ---------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      apix_in     = apix_ff;
      last_vld_in = last_vld_ff;
      last_key_in = last_key_ff;
      last_pix_in = last_pix_ff;
      res_pix_in  = res_pix_ff;
      res_hit_in  = res_hit_ff;
      res_full_in = res_full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               key_in   = {req_bus.blue, req_bus.green, req_bus.red};
               apix_in  = req_bus.alloc_pixel;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // cells register their flags against key_ff at the end of this cycle
            if (cache_hit) begin
               res_pix_in  = last_pix_ff;
               res_hit_in  = 1'b1;
               res_full_in = 1'b0;
               state_in    = ST_RESP;
            end else begin
               state_in = ST_GRP;
            end
         end
         ST_GRP: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (sum_hit_ff) begin
               // table hit refreshes the cache
               last_vld_in = 1'b1;
               last_key_in = key_ff;
               last_pix_in = sum_pix_ff;
               res_pix_in  = sum_pix_ff;
               res_hit_in  = 1'b1;
               res_full_in = 1'b0;
            end else begin
               // miss: inserted by the cells this cycle unless full
               res_pix_in  = apix_ff;
               res_hit_in  = 1'b0;
               res_full_in = table_full;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register, loaded once the previous result has been taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_full_in  = rsp_full_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_RESP) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = res_pix_ff;
         rsp_hit_in   = res_hit_ff;
         rsp_full_in  = res_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_vld_ff  <= 1'b0;
         last_key_ff  <= '0;
         last_pix_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_vld_ff  <= last_vld_in;
         last_key_ff  <= last_key_in;
         last_pix_ff  <= last_pix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      apix_ff     <= apix_in;
      res_pix_ff  <= res_pix_in;
      res_hit_ff  <= res_hit_in;
      res_full_ff <= res_full_in;
      sum_hit_ff  <= sum_hit_in;
      sum_pix_ff  <= sum_pix_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_index = rsp_pix_ff;
   assign rsp_bus.hit         = rsp_hit_ff;
   assign rsp_bus.table_full  = rsp_full_ff;

endmodule

### rtl/sckl_cell.sv
// ----------------------------------------------------------------------------
// sckl_cell
// one entry of the sorted chain: compares, and on insert shifts or loads
// ----------------------------------------------------------------------------
module sckl_cell (
   input  logic               clock,
   input  logic               reset,
   input  sckl_pkg::cmd_type  cmd,
   input  sckl_pkg::cell_type prev_cell,
   input  logic               prev_gt,
   output sckl_pkg::cell_type cell_out,
   output sckl_pkg::flag_type flag
);

   sckl_pkg::cell_type cell_ff, cell_in;
   sckl_pkg::flag_type flag_ff, flag_in;

   always_comb begin
      flag_in.gt = !cell_ff.vld || (cell_ff.key > cmd.key);
      flag_in.eq = cell_ff.vld && (cell_ff.key == cmd.key);
   end

   // cells above the insertion point take their lower neighbor,
   // the lowest of them takes the new entry
   always_comb begin
      cell_in = cell_ff;
      if (cmd.insert && flag_ff.gt) begin
         if (prev_gt) begin
            cell_in = prev_cell;
         end else begin
            cell_in.vld = 1'b1;
            cell_in.key = cmd.key;
            cell_in.pix = cmd.pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
      flag_ff <= flag_in;
   end

   assign cell_out = cell_ff;
   assign flag     = flag_ff;

endmodule

### rtl/sckl_checker.sv
// ----------------------------------------------------------------------------
// sckl_checker
// port level checks of the sorted color key lookup
// ----------------------------------------------------------------------------
`include "sorted_color_key_lookup_insert_macros.svh"

module sckl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [sckl_pkg::PIX_W-1:0] rsp_pixel_index,
   input logic                       rsp_hit,
   input logic                       rsp_table_full
);

   // a stalled response keeps its payload
   `SCKL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_index) && $stable(rsp_hit) && $stable(rsp_table_full), "rsp changed while stalled")

   // a hit never reports a full table
   `SCKL_ASSERT_SAME(a_hit_not_full, rsp_valid, !(rsp_hit && rsp_table_full), "hit and table_full together")

   // one item in flight: no request transfer right after one
   `SCKL_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "ready right after a request transfer")

   // a new response never rises too soon after a request transfer
   `SCKL_ASSERT_SAME(a_min_latency, $rose(rsp_valid), !$past(req_valid && req_ready) && !$past(req_valid && req_ready, 2), "response too soon after request")

endmodule

bind sorted_color_key_lookup_insert sckl_checker u_sckl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_pixel_index (rsp_bus.pixel_index),
   .rsp_hit         (rsp_bus.hit),
   .rsp_table_full  (rsp_bus.table_full)
);
